### src/tmu_pkg.sv
// Package for the triangle metrics unit: field widths, result struct.
// No dependencies.
package tmu_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int PERIM_W = 27;
  localparam int AREA_W  = 40;
  localparam int INR_W   = 23;
  localparam int CIRC_W  = 48;

  typedef struct packed {
    logic [PERIM_W-1:0] perim_q8;
    logic [AREA_W-1:0]  area_q8;
    logic [INR_W-1:0]   inradius_q8;
    logic [CIRC_W-1:0]  circumradius_q8;
    logic               degenerate;
    logic               radius_saturated;
  } result_t;
endpackage

### src/tmu_if.sv
// Valid/ready channel interfaces for the triangle metrics unit.
// Depends on tmu_pkg.
interface tmu_in_if #(parameter int CB = 16);
  logic valid;
  logic ready;
  logic signed [CB-1:0] ax, bx, cx, ay, vert_b_y, cy;
  modport source (output valid, ax, bx, cx, ay, vert_b_y, cy, input ready);
  modport sink (input valid, ax, bx, cx, ay, vert_b_y, cy, output ready);
endinterface

interface tmu_out_if;
  logic valid;
  logic ready;
  tmu_pkg::result_t data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### src/tmu_sqrt_stage.sv
// One restoring step pair of the pipelined integer square root.
// Depends on nothing.
module tmu_sqrt_stage #(
  parameter int W = 80
) (
  input  logic [W-1:0] rem_i,
  input  logic [W/2-1:0] root_i,
  input  logic [1:0] pair_i,
  output logic [W-1:0] rem_o,
  output logic [W/2-1:0] root_o
);
  logic [W+1:0] trial;
  logic [W+1:0] r2;
  always_comb begin
    r2 = {rem_i, pair_i};
    trial = (W+2)'({root_i, 2'b01});
    if (r2 >= trial) begin
      rem_o = W'(r2 - trial);
      root_o = {root_i[W/2-2:0], 1'b1};
    end else begin
      rem_o = W'(r2);
      root_o = {root_i[W/2-2:0], 1'b0};
    end
  end
endmodule

### src/tmu_div_stage.sv
// One restoring step of the pipelined unsigned divider.
// Depends on nothing.
module tmu_div_stage #(
  parameter int W = 64
) (
  input  logic [W-1:0] rem_i,
  input  logic         bit_i,
  input  logic [W-1:0] den_i,
  output logic [W-1:0] rem_o,
  output logic         q_o
);
  logic [W:0] r2;
  always_comb begin
    r2 = {rem_i, bit_i};
    if (r2 >= {1'b0, den_i}) begin
      rem_o = W'(r2 - {1'b0, den_i});
      q_o = 1'b1;
    end else begin
      rem_o = W'(r2);
      q_o = 1'b0;
    end
  end
endmodule

### src/triangle_metrics_unit.sv
// Triangle metrics unit: perimeter, area, inradius, circumradius in fixed point.
// Pipeline: SQ = COORD_BITS+2+FRAC_BITS square-root steps, then LD = 3*SQ divide steps
//   (side-product width).
// Throughput: one transaction per cycle; a stall freezes every stage together.
// Reset clears the stage valid bits only; payload registers are not reset.
// Depends on tmu_pkg, tmu_if, tmu_sqrt_stage, tmu_div_stage.
module triangle_metrics_unit #(
  parameter int COORD_BITS = tmu_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = tmu_pkg::FRAC_BITS_DEF
) (
  input logic clk,
  input logic rst_n,
  tmu_in_if.sink   in_ch,
  tmu_out_if.source out_ch
);
  import tmu_pkg::*;

  localparam int DW  = COORD_BITS + 1;
  localparam int D2W = 2 * DW + 1;
  localparam int SQW = 2 * ((D2W + 2 * FRAC_BITS + 1) / 2);
  localparam int SQ  = SQW / 2;
  localparam int SW  = SQ;
  localparam int PW  = SW + 2;
  localparam int MW  = 2 * DW + 1;
  localparam int AW  = MW + FRAC_BITS;
  localparam int NW  = AW + FRAC_BITS + 1;
  localparam int PRW = 3 * SW;
  localparam int CDW = AW + FRAC_BITS + 2;
  localparam int L1  = SQ;
  localparam int LD  = (NW > PRW) ? NW : PRW;
  localparam int LT  = L1 + 6 + LD;

  typedef struct packed {
    logic [SQW-1:0] rem;
    logic [SQ-1:0]  root;
    logic [SQW-1:0] n;
  } sq_t;

  logic adv;
  assign adv = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  logic [LT:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[LT-1:0], in_ch.valid};
  end

  // stage 0: differences
  logic signed [DW-1:0] dabx_r, daby_r, dbcx_r, dbcy_r, dcax_r, dcay_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      dabx_r <= DW'(in_ch.bx) - DW'(in_ch.ax);
      daby_r <= DW'(in_ch.vert_b_y) - DW'(in_ch.ay);
      dbcx_r <= DW'(in_ch.bx) - DW'(in_ch.cx);
      dbcy_r <= DW'(in_ch.vert_b_y) - DW'(in_ch.cy);
      dcax_r <= DW'(in_ch.cx) - DW'(in_ch.ax);
      dcay_r <= DW'(in_ch.cy) - DW'(in_ch.ay);
    end
  end

  // stage 1: squares and cross terms
  logic [D2W-1:0] d2ab_r, d2bc_r, d2ca_r;
  logic signed [2*DW-1:0] p1_r, p2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      d2ab_r <= D2W'($unsigned((2*DW)'(dabx_r) * (2*DW)'(dabx_r)))
              + D2W'($unsigned((2*DW)'(daby_r) * (2*DW)'(daby_r)));
      d2bc_r <= D2W'($unsigned((2*DW)'(dbcx_r) * (2*DW)'(dbcx_r)))
              + D2W'($unsigned((2*DW)'(dbcy_r) * (2*DW)'(dbcy_r)));
      d2ca_r <= D2W'($unsigned((2*DW)'(dcax_r) * (2*DW)'(dcax_r)))
              + D2W'($unsigned((2*DW)'(dcay_r) * (2*DW)'(dcay_r)));
      p1_r <= (2*DW)'(dabx_r) * (2*DW)'(dcay_r);
      p2_r <= (2*DW)'(daby_r) * (2*DW)'(dcax_r);
    end
  end

  // stage 2: area magnitude, square-root operands
  logic [MW-1:0] mag_r;
  logic signed [MW-1:0] cr;
  assign cr = MW'(p1_r) - MW'(p2_r);
  sq_t sq_r [3][SQ+1];
  logic [MW-1:0] magp_r [SQ+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      magp_r[0] <= cr[MW-1] ? MW'(-cr) : MW'(cr);
      sq_r[0][0] <= '{rem: '0, root: '0, n: SQW'({d2ab_r, {(2*FRAC_BITS){1'b0}}})};
      sq_r[1][0] <= '{rem: '0, root: '0, n: SQW'({d2bc_r, {(2*FRAC_BITS){1'b0}}})};
      sq_r[2][0] <= '{rem: '0, root: '0, n: SQW'({d2ca_r, {(2*FRAC_BITS){1'b0}}})};
    end
  end

  for (genvar s = 0; s < 3; s++) begin : g_side
    for (genvar k = 0; k < SQ; k++) begin : g_step
      logic [SQW-1:0] rem_n;
      logic [SQ-1:0] root_n;
      tmu_sqrt_stage #(.W(SQW)) u_sq (
        .rem_i(sq_r[s][k].rem), .root_i(sq_r[s][k].root),
        .pair_i(sq_r[s][k].n[SQW-1 -: 2]), .rem_o(rem_n), .root_o(root_n));
      always_ff @(posedge clk) begin
        if (adv) sq_r[s][k+1] <= '{rem: rem_n, root: root_n, n: sq_r[s][k].n << 2};
      end
    end
  end
  for (genvar k = 0; k < SQ; k++) begin : g_magd
    always_ff @(posedge clk) begin
      if (adv) magp_r[k+1] <= magp_r[k];
    end
  end
  assign mag_r = magp_r[SQ];

  // stage: perimeter, product part 1
  logic [PW-1:0] per_r;
  logic [2*SW-1:0] pab_r;
  logic [SW-1:0] sca_r;
  logic [MW-1:0] mag2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      per_r <= PW'(sq_r[0][SQ].root) + PW'(sq_r[1][SQ].root) + PW'(sq_r[2][SQ].root);
      pab_r <= (2*SW)'(sq_r[0][SQ].root) * (2*SW)'(sq_r[1][SQ].root);
      sca_r <= sq_r[2][SQ].root;
      mag2_r <= mag_r;
    end
  end

  // stage: side product, split into low and high partial products
  logic [2*SW-1:0] prodl_r, prodh_r;
  logic [PW-1:0] per2_r;
  logic [MW-1:0] mag3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      prodl_r <= (2*SW)'(pab_r[SW-1:0]) * (2*SW)'(sca_r);
      prodh_r <= (2*SW)'(pab_r[2*SW-1:SW]) * (2*SW)'(sca_r);
      per2_r <= per_r;
      mag3_r <= mag2_r;
    end
  end

  // divide pipeline: inradius and circumradius in parallel
  typedef struct packed {
    logic [LD-1:0]  na;
    logic [PW-1:0]  ra;
    logic [LD-1:0]  qa;
    logic [LD-1:0]  nb;
    logic [CDW-1:0] rb;
    logic [LD-1:0]  qb;
    logic [PW-1:0]  per;
    logic [MW-1:0]  mag;
  } dv_t;
  dv_t dv_r [LD+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0] <= '{na: LD'({mag3_r, {(2*FRAC_BITS){1'b0}}}), ra: '0, qa: '0,
                   nb: LD'({prodh_r, {SW{1'b0}}}) + LD'(prodl_r), rb: '0, qb: '0,
                   per: per2_r, mag: mag3_r};
    end
  end
  for (genvar k = 0; k < LD; k++) begin : g_div
    logic [PW-1:0] ran;
    logic [CDW-1:0] rbn;
    logic qan, qbn;
    dv_t cur;
    assign cur = dv_r[k];
    tmu_div_stage #(.W(PW)) u_da (
      .rem_i(cur.ra), .bit_i(cur.na[LD-1]), .den_i(cur.per), .rem_o(ran), .q_o(qan));
    tmu_div_stage #(.W(CDW)) u_db (
      .rem_i(cur.rb), .bit_i(cur.nb[LD-1]),
      .den_i(CDW'({cur.mag, {(2*FRAC_BITS+1){1'b0}}})), .rem_o(rbn), .q_o(qbn));
    always_ff @(posedge clk) begin
      if (adv) dv_r[k+1] <= '{na: cur.na << 1, ra: ran, qa: {cur.qa[LD-2:0], qan},
                              nb: cur.nb << 1, rb: rbn, qb: {cur.qb[LD-2:0], qbn},
                              per: cur.per, mag: cur.mag};
    end
  end

  // output register
  dv_t fin;
  logic dg;
  result_t res_r;
  assign fin = dv_r[LD];
  assign dg = (fin.mag == '0);
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r.perim_q8 <= PERIM_W'(fin.per);
      res_r.area_q8 <= AREA_W'({fin.mag, {(FRAC_BITS-1){1'b0}}});
      res_r.inradius_q8 <= (dg || fin.per == '0) ? '0 : INR_W'(fin.qa);
      res_r.degenerate <= dg;
      if (dg || (fin.qb > LD'({CIRC_W{1'b1}}))) begin
        res_r.circumradius_q8 <= '1;
        res_r.radius_saturated <= 1'b1;
      end else begin
        res_r.circumradius_q8 <= CIRC_W'(fin.qb);
        res_r.radius_saturated <= 1'b0;
      end
    end
  end

  assign out_ch.valid = v_r[LT];
  assign out_ch.data = res_r;
endmodule

### tb/tb_top.sv
// Testbench for triangle_metrics_unit: directed table then random vertex triples,
// checked against a built-in bit-exact predictor, but for four directed rows with typed results.
// Depends on tmu_pkg, the tmu_in_if / tmu_out_if interfaces and triangle_metrics_unit.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import tmu_pkg::*;

  localparam int CB = 16;
  localparam int N_RAND = 1200;
  localparam int WATCHDOG = 20000;
  localparam int DRAIN = 400;
  localparam logic [CIRC_W-1:0] CIRC_MAX = '1;

  typedef struct {
    logic signed [CB-1:0] ax, bx, cx, ay, by, cy;
  } tri_t;

  typedef struct {
    tri_t    t;
    bit      typed;
    result_t res;
  } row_t;

  logic clk;
  logic rst_n;
  tmu_in_if #(CB) in_ch();
  tmu_out_if out_ch();

  triangle_metrics_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  result_t metrics_q[$];
  row_t    rows[$];
  int      errors = 0;
  int      src_idle = 15;
  int      dst_idle = 57;
  int      quiet = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] isqrt64(logic [63:0] n);
    logic [63:0] res, b;
    res = '0;
    b = 64'd1 << 62;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] side_q8(longint dx, longint dy);
    logic [63:0] d2;
    d2 = dx * dx + dy * dy;
    return isqrt64(d2 << 16);
  endfunction

  function automatic result_t tri_metrics(tri_t t);
    longint xa, xb, xc, ya, yb, yc, cr;
    logic [63:0] sab, sbc, sca, mag;
    logic [127:0] perim, area, prod, q, inr;
    result_t r;
    xa = t.ax; xb = t.bx; xc = t.cx;
    ya = t.ay; yb = t.by; yc = t.cy;
    sab = side_q8(xb - xa, yb - ya);
    sbc = side_q8(xb - xc, yb - yc);
    sca = side_q8(xc - xa, yc - ya);
    perim = 128'(sab) + 128'(sbc) + 128'(sca);
    cr = (xb - xa) * (yc - ya) - (yb - ya) * (xc - xa);
    mag = cr < 0 ? 64'(-cr) : 64'(cr);
    area = 128'(mag) << 7;
    inr = '0;
    r.circumradius_q8 = CIRC_MAX;
    r.radius_saturated = 1'b1;
    r.degenerate = (mag == 0);
    if (mag != 0) begin
      if (perim != 0) inr = (area << 9) / perim;
      prod = 128'(sab) * 128'(sbc) * 128'(sca);
      q = prod / (area << 10);
      if (q <= 128'(CIRC_MAX)) begin
        r.circumradius_q8 = q[CIRC_W-1:0];
        r.radius_saturated = 1'b0;
      end
    end
    r.perim_q8 = perim[PERIM_W-1:0];
    r.area_q8 = area[AREA_W-1:0];
    r.inradius_q8 = inr[INR_W-1:0];
    return r;
  endfunction

  function automatic tri_t mk(int ax, int ay, int bx, int by, int cx, int cy);
    tri_t t;
    t.ax = CB'(ax); t.ay = CB'(ay); t.bx = CB'(bx);
    t.by = CB'(by); t.cx = CB'(cx); t.cy = CB'(cy);
    return t;
  endfunction

  function automatic void add_row(tri_t t, bit typed, result_t res);
    row_t r;
    r.t = t; r.typed = typed; r.res = res;
    rows.push_back(r);
  endfunction

  function automatic result_t degen_res(logic [PERIM_W-1:0] p);
    result_t r;
    r = '{perim_q8: p, area_q8: '0, inradius_q8: '0, circumradius_q8: CIRC_MAX,
          degenerate: 1'b1, radius_saturated: 1'b1};
    return r;
  endfunction

  function automatic int rnd_small();
    return int'($urandom_range(16)) - 8;
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    int k, dx, dy, m, o;
    int ext[4] = '{-32768, -1, 0, 32767};
    k = $urandom_range(9);
    if (k <= 4) begin
      t.ax = CB'($urandom); t.bx = CB'($urandom); t.cx = CB'($urandom);
      t.ay = CB'($urandom); t.by = CB'($urandom); t.cy = CB'($urandom);
    end else if (k <= 6) begin
      t = mk(rnd_small(), rnd_small(), rnd_small(), rnd_small(), rnd_small(), rnd_small());
    end else if (k == 7) begin
      t.ax = CB'($urandom); t.ay = CB'($urandom);
      dx = rnd_small(); dy = rnd_small();
      m = $urandom_range(2000); o = int'($urandom_range(4000)) - 2000;
      t.bx = CB'(int'(t.ax) + dx * m); t.by = CB'(int'(t.ay) + dy * m);
      t.cx = CB'(int'(t.ax) + dx * o); t.cy = CB'(int'(t.ay) + dy * o);
    end else if (k == 8) begin
      t.ax = CB'($urandom); t.ay = CB'($urandom);
      t.bx = CB'($urandom); t.by = CB'($urandom);
      t.cx = CB'((int'(t.ax) + int'(t.bx)) / 2 + int'($urandom_range(2)) - 1);
      t.cy = CB'((int'(t.ay) + int'(t.by)) / 2 + int'($urandom_range(2)) - 1);
    end else begin
      t = mk(ext[$urandom_range(3)], ext[$urandom_range(3)], ext[$urandom_range(3)],
             ext[$urandom_range(3)], ext[$urandom_range(3)], ext[$urandom_range(3)]);
    end
    return t;
  endfunction

  task automatic send_tri(tri_t t, result_t res);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.ax <= t.ax; in_ch.bx <= t.bx; in_ch.cx <= t.cx;
    in_ch.ay <= t.ay; in_ch.vert_b_y <= t.by; in_ch.cy <= t.cy;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    metrics_q.push_back(res);
    @(negedge clk);
  endtask

  initial begin
    result_t z;
    int total;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.ax = '0; in_ch.bx = '0; in_ch.cx = '0;
    in_ch.ay = '0; in_ch.vert_b_y = '0; in_ch.cy = '0;
    out_ch.ready = 1'b0;
    z = '0;

    add_row(mk(0, 0, 0, 0, 0, 0), 1'b1, degen_res(0));
    add_row(mk(-32768, 32767, -32768, 32767, -32768, 32767), 1'b1, degen_res(0));
    add_row(mk(0, 0, 1, 1, 2, 2), 1'b1, degen_res(1448));
    add_row(mk(-32768, 0, 32767, 0, 0, 0), 1'b1, degen_res(33553920));
    add_row(mk(5, 5, 5, 5, 9, 9), 1'b0, z);
    add_row(mk(0, 0, 3, 0, 0, 4), 1'b0, z);
    add_row(mk(0, 0, 1, 0, 0, 1), 1'b0, z);
    add_row(mk(-32768, -32768, 32767, -32768, -32768, 32767), 1'b0, z);
    add_row(mk(32767, 32767, -32768, 32767, 32767, -32768), 1'b0, z);
    add_row(mk(-32768, -32768, 32767, 32767, 32767, -32768), 1'b0, z);
    add_row(mk(-32768, -32767, 32767, 32766, 0, 0), 1'b0, z);
    add_row(mk(-32768, -32767, 32767, 32766, 0, -1), 1'b0, z);
    add_row(mk(0, 0, 32767, 32766, 1, 1), 1'b0, z);
    add_row(mk(-1, -1, -1, 0, 0, -1), 1'b0, z);
    add_row(mk(-32768, 0, 32767, 0, 0, 32767), 1'b0, z);
    add_row(mk(-32768, 0, 32767, 0, 0, 1), 1'b0, z);
    add_row(mk(0, -32768, 0, 32767, 1, 0), 1'b0, z);
    add_row(mk(-21845, -32768, 21845, -32768, 0, 32767), 1'b0, z);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (rows[i]) send_tri(rows[i].t, rows[i].typed ? rows[i].res : tri_metrics(rows[i].t));

    total = N_RAND;
    for (int i = 0; i < total; i++) begin
      tri_t t;
      if (i == total / 3) begin
        src_idle = 57; dst_idle = 15;
      end else if (i == 2 * total / 3) begin
        src_idle = 0; dst_idle = 0;
      end
      t = rand_tri();
      send_tri(t, tri_metrics(t));
    end
    in_ch.valid <= 1'b0;

    while (metrics_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (rst_n) out_ch.ready <= ($urandom_range(99) >= dst_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (metrics_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        result_t e, a;
        e = metrics_q.pop_front();
        a = out_ch.data;
        if (a.perim_q8 !== e.perim_q8) begin
          $error("perim_q8 exp %0d got %0d", e.perim_q8, a.perim_q8); errors++;
        end
        if (a.area_q8 !== e.area_q8) begin
          $error("area_q8 exp %0d got %0d", e.area_q8, a.area_q8); errors++;
        end
        if (a.inradius_q8 !== e.inradius_q8) begin
          $error("inradius_q8 exp %0d got %0d", e.inradius_q8, a.inradius_q8); errors++;
        end
        if (a.circumradius_q8 !== e.circumradius_q8) begin
          $error("circumradius_q8 exp %0d got %0d", e.circumradius_q8, a.circumradius_q8);
          errors++;
        end
        if (a.degenerate !== e.degenerate) begin
          $error("degenerate exp %0d got %0d", e.degenerate, a.degenerate); errors++;
        end
        if (a.radius_saturated !== e.radius_saturated) begin
          $error("radius_saturated exp %0d got %0d", e.radius_saturated, a.radius_saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end
endmodule
